// ===== rtl/scfl_pkg.sv =====
package scfl_pkg;

   localparam int PoolPages = 64;
   localparam int PageBytes = 4096;
   localparam int NumClasses = 7;
   localparam int UnitShift = 5;
   localparam int HdrBytes = 8;
   localparam int PoolBytes = PoolPages * PageBytes;
   localparam int LinkDepth = PoolBytes >> UnitShift;
   localparam int CellW = 13;
   localparam int HeadW = 14;
   localparam int AddrW = 18;
   localparam int PageW = 6;
   localparam int ClaimW = 7;
   localparam int ClsW = 3;
   localparam int PageShift = 12;
   localparam int PageCountW = 21;

   localparam logic [2:0] ST_ALLOC = 3'd0;
   localparam logic [2:0] ST_LARGE = 3'd1;
   localparam logic [2:0] ST_RELEASE = 3'd2;
   localparam logic [2:0] ST_OOM = 3'd3;
   localparam logic [2:0] ST_FREED = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic finish;
   } cmd_type;

endpackage

// ===== rtl/scfl_ram.sv =====
module scfl_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/scfl_ctrl.sv =====
module scfl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output scfl_pkg::cmd_type cmd
);
   import scfl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_READ;
         S_READ: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // The memories are addressed in S_READ, and their data is used in S_DONE.
   always_comb begin
      cmd.capture = 1'b0;
      cmd.finish = 1'b0;
      busy = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            cmd.capture = start;
         end
         S_DONE: cmd.finish = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== rtl/scfl_dp.sv =====
module scfl_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  scfl_pkg::cmd_type     cmd,
   input  logic                  req_type,
   input  logic [31:0]           req_size,
   input  logic [31:0]           free_address,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [17:0]           rsp_cell_address,
   output logic [20:0]           rsp_page_count,
   output logic [2:0]            rsp_size_class
);
   import scfl_pkg::*;

   logic [HeadW-1:0] head_ff [NumClasses];
   logic [HeadW-1:0] head_in [NumClasses];
   logic [AddrW-1:0] carve_ff [NumClasses];
   logic [AddrW-1:0] carve_in [NumClasses];
   logic [NumClasses-1:0] cvalid_ff, cvalid_in;
   logic [ClaimW-1:0] claimed_ff, claimed_in;
   logic [ClsW-1:0] pclass_in;
   logic pclass_we;
   logic [PageW-1:0] pclass_wa;

   // Captured item and precomputed decode.
   logic type_ff;
   logic large_ff;
   logic [PageCountW-1:0] pages_ff;
   logic [ClsW-1:0] acls_ff;
   logic rel_ff;
   logic [PageW-1:0] fpage_ff;
   logic [PageShift-1:0] foff_ff;
   logic fclaimed_ff;

   logic valid_ff;
   logic [2:0] st_ff, st_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [PageCountW-1:0] pc_ff, pc_in;
   logic [ClsW-1:0] cls_ff, cls_in;

   // Decode of the incoming item.
   logic [32:0] s;
   logic [ClsW-1:0] kdec;
   logic [20:0] pgraw;
   logic [31:0] fbase;
   always_comb begin
      s = ((req_size < 32'd16) ? 33'd16 : {1'b0, req_size}) + 33'(HdrBytes);
      kdec = ClsW'(NumClasses - 1);
      for (int i = NumClasses - 2; i >= 0; i--) begin
         if (s <= (33'd32 << i)) kdec = ClsW'(i);
      end
      pgraw = (s[32:PageShift] + ((s[PageShift-1:0] != '0) ? 21'd1 : 21'd0)) > 21'd1048576
              ? 21'd1048576
              : 21'(s[32:PageShift] + ((s[PageShift-1:0] != '0) ? 21'd1 : 21'd0));
      fbase = free_address - 32'(HdrBytes);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         large_ff <= s >= (33'd32 << (NumClasses - 1));
         pages_ff <= pgraw;
         acls_ff <= kdec;
         rel_ff <= (free_address >= 32'(PoolBytes)) || (free_address < 32'(HdrBytes));
         fpage_ff <= fbase[PageShift +: PageW];
         foff_ff <= fbase[PageShift-1:0];
         fclaimed_ff <= {1'b0, fbase[PageShift +: PageW]} < claimed_ff;
      end
   end

   // Stage one: address the link memory and the page class table.
   logic [HeadW-1:0] ahead;
   logic [ClsW-1:0] fcls;
   logic [ClsW-1:0] fcls_raw;
   logic [PageShift-1:0] fidx;
   logic fin_page;
   logic [CellW-1:0] fcell;
   logic [ClsW-1:0] use_cls;

   scfl_ram #(.Width(ClsW), .Depth(PoolPages)) u_pclass (
      .clock  (clock),
      .wr_en  (pclass_we),
      .wr_addr(pclass_wa),
      .wr_data(pclass_in),
      .rd_addr(fpage_ff),
      .rd_data(fcls_raw)
   );

   always_comb begin
      ahead = head_ff[acls_ff];
      fcls = (fcls_raw >= ClsW'(NumClasses)) ? ClsW'(NumClasses - 1) : fcls_raw;
      fidx = foff_ff >> (UnitShift + fcls);
      fin_page = 32'(fidx) < (32'(PageBytes) >> (UnitShift + fcls));
      fcell = {fpage_ff, (PageShift - UnitShift)'(fidx << fcls)};
      use_cls = type_ff ? fcls : acls_ff;
   end

   logic link_we;
   logic [CellW-1:0] link_wa;
   logic [HeadW-1:0] link_wd;
   logic [HeadW-1:0] link_q;

   scfl_ram #(.Width(HeadW), .Depth(LinkDepth)) u_link (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_wa),
      .wr_data(link_wd),
      .rd_addr(ahead[CellW-1:0]),
      .rd_data(link_q)
   );

   // Stage two: resolve and update.
   logic [AddrW-1:0] caddr;
   logic [31:0] csize;
   logic [31:0] off;
   logic [31:0] cells;
   always_comb begin
      for (int i = 0; i < NumClasses; i++) begin
         head_in[i] = head_ff[i];
         carve_in[i] = carve_ff[i];
      end
      cvalid_in = cvalid_ff;
      claimed_in = claimed_ff;
      pclass_we = 1'b0;
      pclass_wa = claimed_ff[PageW-1:0];
      pclass_in = acls_ff;
      link_we = 1'b0;
      link_wa = fcell;
      link_wd = head_ff[use_cls];
      st_in = ST_ALLOC;
      addr_in = '0;
      pc_in = '0;
      cls_in = '0;
      csize = 32'd32 << acls_ff;
      cells = 32'(PageBytes) >> (UnitShift + acls_ff);
      caddr = cvalid_ff[acls_ff] ? carve_ff[acls_ff]
              : AddrW'(32'(claimed_ff) << PageShift);
      off = 32'(caddr[PageShift-1:0]) + csize;
      if (cmd.finish) begin
         if (!type_ff) begin
            if (large_ff) begin
               st_in = ST_LARGE;
               pc_in = pages_ff;
            end else if (ahead < HeadW'(LinkDepth)) begin
               head_in[acls_ff] = link_q;
               addr_in = AddrW'({ahead, 5'd0} + HdrBytes);
               cls_in = acls_ff;
            end else if (!cvalid_ff[acls_ff] &&
                         (cells == 0 || claimed_ff >= ClaimW'(PoolPages))) begin
               st_in = ST_OOM;
               cls_in = acls_ff;
            end else begin
               if (!cvalid_ff[acls_ff]) begin
                  pclass_we = 1'b1;
                  claimed_in = claimed_ff + 1'b1;
               end
               if (off + csize > (cells << (UnitShift + acls_ff))) begin
                  cvalid_in[acls_ff] = 1'b0;
                  carve_in[acls_ff] = '0;
               end else begin
                  cvalid_in[acls_ff] = 1'b1;
                  carve_in[acls_ff] = caddr + AddrW'(csize);
               end
               addr_in = caddr + AddrW'(HdrBytes);
               cls_in = acls_ff;
            end
         end else if (rel_ff) begin
            st_in = ST_RELEASE;
         end else if (!fclaimed_ff || !fin_page) begin
            st_in = ST_FREED;
         end else begin
            st_in = ST_FREED;
            link_we = 1'b1;
            head_in[fcls] = {1'b0, fcell};
            addr_in = AddrW'({fcell, 5'd0} + HdrBytes);
            cls_in = fcls;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      addr_ff <= addr_in;
      pc_ff <= pc_in;
      cls_ff <= cls_in;
      if (reset) begin
         for (int i = 0; i < NumClasses; i++) begin
            head_ff[i] <= HeadW'(LinkDepth);
            carve_ff[i] <= '0;
         end
         cvalid_ff <= '0;
         claimed_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NumClasses; i++) begin
            head_ff[i] <= head_in[i];
            carve_ff[i] <= carve_in[i];
         end
         cvalid_ff <= cvalid_in;
         claimed_ff <= claimed_in;
         valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = st_ff;
   assign rsp_cell_address = addr_ff;
   assign rsp_page_count = pc_ff;
   assign rsp_size_class = cls_ff;
endmodule

// ===== rtl/size_class_free_list_allocator.sv =====
// Size-class cell allocator over a 64-page pool of 4096-byte pages.
// Input channel: raise start with req_type (0 allocate, 1 free), req_size
// and free_address; the item is taken at the edge where start is high and
// busy is low. busy stays high until the result has been presented.
// Result channel: rsp_valid is high for one cycle with rsp_status,
// rsp_cell_address, rsp_page_count and rsp_size_class. The receiver cannot
// stall; the result must be taken in that cycle.
// Sequence: the item is captured at acceptance, the memories are read in
// S_READ and the result is registered from S_DONE; a new item can be
// accepted at the edge that ends the cycle the result is shown. This order
// is set by the registered reads of the cell link memory and the page class
// table, whose data must be back before the class head can be updated.
// Reset: all class stacks become empty, no page is claimed and no carve
// page is open. The link memory and page class table need no clearing,
// since only entries written earlier are ever used.
module size_class_free_list_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [17:0] rsp_cell_address,
   output logic [20:0] rsp_page_count,
   output logic [2:0]  rsp_size_class
);
   import scfl_pkg::*;

   cmd_type cmd;

   scfl_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .cmd  (cmd)
   );

   scfl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_size        (req_size),
      .free_address    (req_free_address),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_cell_address(rsp_cell_address),
      .rsp_page_count  (rsp_page_count),
      .rsp_size_class  (rsp_size_class)
   );
endmodule

// ===== bench/size_class_free_list_allocator_tb.sv =====
module size_class_free_list_allocator_tb;
   import scfl_pkg::*;

   typedef struct {
      logic        is_free;
      logic [31:0] size;
      logic [31:0] addr;
   } request_type;

   typedef struct {
      logic [2:0]  status;
      logic [17:0] cell_address;
      logic [20:0] page_count;
      logic [2:0]  size_class;
   } result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [31:0] req_size;
   logic [31:0] req_free_address;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [17:0] rsp_cell_address;
   logic [20:0] rsp_page_count;
   logic [2:0]  rsp_size_class;

   size_class_free_list_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_size(req_size),
      .req_free_address(req_free_address), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_cell_address(rsp_cell_address),
      .rsp_page_count(rsp_page_count), .rsp_size_class(rsp_size_class)
   );

   // Allocator shadow state.
   logic [HeadW-1:0]  stack_top [NumClasses];
   logic [AddrW-1:0]  carve_at [NumClasses];
   logic              carve_open [NumClasses];
   logic [HeadW-1:0]  next_below [LinkDepth];
   logic [ClsW-1:0]   page_owner [PoolPages];
   int unsigned       claimed;

   request_type pending_reqs[$];
   result_type  awaited[$];
   int          errors = 0;
   int          n_items = 0;
   int          n_sent = 0;
   int          n_results = 0;
   int          gap_left = 0;
   int          idle_cnt = 0;
   bit          quiet_tail = 0;

   function automatic result_type allocate(input logic [31:0] size);
      result_type r;
      longint unsigned s;
      longint unsigned pg;
      int k;
      int unsigned cs;
      int unsigned cells;
      int unsigned a;
      r = '{ST_ALLOC, 0, 0, 0};
      s = (size < 16) ? 16 : size;
      s += HdrBytes;
      if (s >= (32 << (NumClasses - 1))) begin
         pg = (s + PageBytes - 1) / PageBytes;
         if (pg > 1048576) pg = 1048576;
         r.status = ST_LARGE;
         r.page_count = pg[20:0];
         return r;
      end
      k = 0;
      while (k + 1 < NumClasses && (32 << k) < s) k++;
      cs = 32 << k;
      r.size_class = k[2:0];
      if (stack_top[k] < LinkDepth) begin
         r.cell_address = AddrW'((int'(stack_top[k]) << UnitShift) + HdrBytes);
         stack_top[k] = next_below[stack_top[k]];
         return r;
      end
      cells = PageBytes / cs;
      if (!carve_open[k]) begin
         if (cells == 0 || claimed >= PoolPages) begin
            r.status = ST_OOM;
            return r;
         end
         page_owner[claimed] = k[2:0];
         carve_at[k] = AddrW'(claimed * PageBytes);
         carve_open[k] = 1;
         claimed++;
      end
      a = carve_at[k];
      if ((a % PageBytes) + 2 * cs > cells * cs) begin
         carve_open[k] = 0;
         carve_at[k] = 0;
      end else begin
         carve_at[k] = AddrW'(a + cs);
      end
      r.cell_address = AddrW'(a + HdrBytes);
      return r;
   endfunction

   function automatic result_type free_cell(input logic [31:0] addr);
      result_type r;
      int unsigned base;
      int unsigned pg;
      int unsigned k;
      int unsigned cs;
      int unsigned idx;
      int unsigned cb;
      int unsigned c;
      r = '{ST_FREED, 0, 0, 0};
      if (addr >= PoolBytes || addr < HdrBytes) begin
         r.status = ST_RELEASE;
         return r;
      end
      base = addr - HdrBytes;
      pg = base / PageBytes;
      if (pg >= claimed) return r;
      k = page_owner[pg];
      if (k >= NumClasses) k = NumClasses - 1;
      cs = 32 << k;
      idx = (base % PageBytes) / cs;
      if (idx >= PageBytes / cs) return r;
      cb = pg * PageBytes + idx * cs;
      c = cb >> UnitShift;
      if (c >= LinkDepth) c = LinkDepth - 1;
      next_below[c] = stack_top[k];
      stack_top[k] = HeadW'(c);
      r.cell_address = AddrW'(cb + HdrBytes);
      r.size_class = k[2:0];
      return r;
   endfunction

   task automatic push_alloc(input logic [31:0] size);
      pending_reqs.push_back('{1'b0, size, $urandom});
   endtask

   task automatic push_free(input logic [31:0] addr);
      pending_reqs.push_back('{1'b1, $urandom, addr});
   endtask

   // Picks a request size landing in a random class, sometimes small.
   function automatic logic [31:0] class_size();
      int k;
      k = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 1);
      return $urandom_range(k == 0 ? 0 : (16 << k) - 7, (32 << k) - 8);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver: presents items at the falling edge with random bursts of idle.
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && n_items != n_sent) begin
         // Item not taken yet; hold it.
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start <= 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         gap_left <= $urandom_range(1, 17) - 1;
         start <= 0;
      end else if (pending_reqs.size() > 0) begin
         request_type q;
         q = pending_reqs.pop_front();
         start <= 1;
         n_sent <= n_sent + 1;
         req_type <= q.is_free;
         req_size <= q.size;
         req_free_address <= q.addr;
      end else begin
         start <= 0;
      end
   end

   // Monitor: predicts on acceptance and checks each result.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            n_items++;
            if (req_type) awaited.push_back(free_cell(req_free_address));
            else awaited.push_back(allocate(req_size));
            idle_cnt <= 0;
         end else if (rsp_valid) begin
            idle_cnt <= 0;
         end else begin
            idle_cnt <= idle_cnt + 1;
         end
         if (rsp_valid) begin
            n_results++;
            if (awaited.size() == 0) begin
               $error("unexpected result, status %0d", rsp_status);
               errors++;
            end else begin
               result_type e;
               e = awaited.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_cell_address !== e.cell_address) begin
                  $error("cell_address: expected %0h, got %0h",
                         e.cell_address, rsp_cell_address);
                  errors++;
               end
               if (rsp_page_count !== e.page_count) begin
                  $error("page_count: expected %0d, got %0d",
                         e.page_count, rsp_page_count);
                  errors++;
               end
               if (rsp_size_class !== e.size_class) begin
                  $error("size_class: expected %0d, got %0d",
                         e.size_class, rsp_size_class);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if (idle_cnt > 2000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int i;
      int j;
      for (i = 0; i < NumClasses; i++) begin
         stack_top[i] = HeadW'(LinkDepth);
         carve_at[i] = 0;
         carve_open[i] = 0;
      end
      claimed = 0;
      reset = 1;
      start = 0;
      req_type = 0;
      req_size = 0;
      req_free_address = 0;

      // Directed: free before any page, extremes, every class, large and
      // saturated page counts, misaligned, tail and out-of-pool frees.
      push_free(32'd100);
      push_free(32'd0);
      push_free(32'd7);
      push_free(32'hFFFF_FFFF);
      push_free(PoolBytes);
      push_alloc(32'd0);
      push_alloc(32'd24);
      push_alloc(32'd25);
      push_alloc(32'd56);
      push_alloc(32'd120);
      push_alloc(32'd248);
      push_alloc(32'd504);
      push_alloc(32'd1016);
      push_alloc(32'd2039);
      push_alloc(32'd2040);
      push_alloc(32'hFFFF_FFFF);
      push_alloc(32'd8192);
      push_free(32'd8 + 32'd5);
      push_free(32'd8);
      push_alloc(32'd10);
      push_free(32'd8);
      push_free(32'd8);
      push_free(32'd4096 * 6 + 8 + 4000);
      push_free(PoolBytes - 1);
      push_free(32'd4096 * 30);

      // Random: mostly allocate and free of likely cell addresses, some noise.
      for (i = 0; i < 1355; i++) begin
         j = $urandom_range(0, 99);
         if (i == 700) begin
            // Push the pool toward its limit with a burst of allocations.
            for (int p = 0; p < 70; p++) push_alloc($urandom_range(505, 1016));
         end
         if (j < 50) push_alloc(class_size());
         else if (j < 85) push_free(32'($urandom_range(1, 1400) * 32 + 8));
         else if (j < 90) push_free($urandom_range(0, PoolBytes - 1));
         else if (j < 93) push_free($urandom);
         else if (j < 97) push_alloc($urandom);
         else push_alloc($urandom_range(1024, 40000));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      wait (pending_reqs.size() < 150);
      quiet_tail = 1;
      wait (pending_reqs.size() == 0 && !start);
      wait (awaited.size() == 0);
      repeat (10) @(posedge clock);
      $display("Ran %0d items, %0d results checked, %0d pages claimed.",
               n_items, n_results, claimed);
      $display("Covered all classes, large, out-of-pool, stale and repeated frees.");
      if (errors == 0 && awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/scfl_pkg.sv
rtl/scfl_ram.sv
rtl/scfl_ctrl.sv
rtl/scfl_dp.sv
rtl/size_class_free_list_allocator.sv
bench/size_class_free_list_allocator_tb.sv
